/* rtl/core/hc67_pkg.sv */
package hc67_pkg;

  // Alphabet: digits, upper case, lower case, then space . , ; -
  localparam int unsigned SymCount = 67;

  localparam logic [6:0] IdxUpper  = 7'd10;
  localparam logic [6:0] IdxLower  = 7'd36;
  localparam logic [6:0] IdxSpace  = 7'd62;
  localparam logic [6:0] IdxPeriod = 7'd63;
  localparam logic [6:0] IdxComma  = 7'd64;
  localparam logic [6:0] IdxSemi   = 7'd65;
  localparam logic [6:0] IdxHyphen = 7'd66;
  localparam logic [6:0] PadIndex  = IdxSpace;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPeriod = 8'h2e;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChHyphen = 8'h2d;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } hc67_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } hc67_out_t;

  typedef struct packed {
    logic       vld;
    logic [6:0] idx;
  } hc67_sym_t;

  typedef logic [255:0][6:0]         hc67_fold_t;
  typedef logic [SymCount-1:0][6:0] hc67_inv_t;

  // (h * 64) mod 67 for every 8-bit h, built by repeated addition.
  function automatic hc67_fold_t build_fold_tab();
    hc67_fold_t t;
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 256; i++) begin
      t[i] = acc[6:0];
      acc  = acc + 8'd64;
      if (acc >= 8'(SymCount)) acc = acc - 8'(SymCount);
    end
    return t;
  endfunction

  // Multiplicative inverse mod 67, zero maps to zero.
  function automatic hc67_inv_t build_inv_tab();
    hc67_inv_t t;
    int unsigned acc;
    int unsigned inv;
    for (int x = 0; x < SymCount; x++) begin
      acc = 0;
      inv = 0;
      for (int y = 1; y < SymCount; y++) begin
        acc = acc + x;
        if (acc >= SymCount) acc = acc - SymCount;
        if (acc == 1) inv = y;
      end
      t[x] = 7'(inv);
    end
    return t;
  endfunction

  localparam hc67_fold_t FoldTab = build_fold_tab();
  localparam hc67_inv_t  InvTab  = build_inv_tab();

  // x mod 67 for x < 2^14: x = 64*hi + lo, fold hi through the table.
  function automatic logic [6:0] mod67(input logic [13:0] x);
    logic [7:0] t;
    t = {1'b0, FoldTab[x[13:6]]} + {2'b00, x[5:0]};
    if (t >= 8'(SymCount)) t = t - 8'(SymCount);
    return t[6:0];
  endfunction

  function automatic hc67_sym_t sym_lookup(input logic [7:0] ch);
    hc67_sym_t s;
    s.vld = 1'b1;
    s.idx = '0;
    if (ch >= ChZero && ch <= ChNine) begin
      s.idx = 7'(ch - ChZero);
    end else if (ch >= ChUpperA && ch <= ChUpperZ) begin
      s.idx = 7'(ch - ChUpperA) + IdxUpper;
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      s.idx = 7'(ch - ChLowerA) + IdxLower;
    end else begin
      case (ch)
        ChSpace:  s.idx = IdxSpace;
        ChPeriod: s.idx = IdxPeriod;
        ChComma:  s.idx = IdxComma;
        ChSemi:   s.idx = IdxSemi;
        ChHyphen: s.idx = IdxHyphen;
        default:  s.vld = 1'b0;
      endcase
    end
    return s;
  endfunction

  function automatic logic [7:0] sym_char(input logic [6:0] idx);
    logic [7:0] c;
    if (idx < IdxUpper) begin
      c = ChZero + 8'(idx);
    end else if (idx < IdxLower) begin
      c = ChUpperA + 8'(idx - IdxUpper);
    end else if (idx < IdxSpace) begin
      c = ChLowerA + 8'(idx - IdxLower);
    end else begin
      case (idx)
        IdxSpace:  c = ChSpace;
        IdxPeriod: c = ChPeriod;
        IdxComma:  c = ChComma;
        IdxSemi:   c = ChSemi;
        IdxHyphen: c = ChHyphen;
        default:   c = ChZero;
      endcase
    end
    return c;
  endfunction

endpackage

/* rtl/core/hill_cipher_2x2_mod67.sv */
// 2x2 Hill cipher over a 67-symbol alphabet (0-9, A-Z, a-z, space . , ; -).
// One message byte is accepted per clock while in_stall_o is low; bytes
// outside the alphabet are dropped. The first symbol of a pair is held, the
// second produces two cipher words (first, then second; out_last rides on the
// second word of the pair that ends a message). An unpaired symbol at in_last
// is padded with a space. The byte that completes a pair passes through the
// pair register, the product registers and the output queue before the first
// word of the pair is on the output. The input side takes one byte per cycle
// unless stalled; the output port moves one word per cycle unless out_stall_i
// holds it, so a pair occupies it for two words and a stream in which every
// byte completes a pair is paced by the output. A four-pair output queue lets
// the input keep going while a word waits on out_stall_i. Key registers are
// APB-mapped at 4*i (key_a..key_d, then decrypt_mode); key values 67..127 are
// taken mod 67. Decrypt uses the inverse key derived in a six-stage register
// pipeline; after reset and after any register write the input stalls while it settles.
module hill_cipher_2x2_mod67 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hc67_pkg::hc67_in_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hc67_pkg::hc67_out_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hc67_pkg::*;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;
  localparam int unsigned CreditW   = CntW + 1;
  localparam logic [2:0]  KeySettle = 3'd6;

  typedef enum logic [2:0] {
    RegKeyA = 3'd0,
    RegKeyB = 3'd1,
    RegKeyC = 3'd2,
    RegKeyD = 3'd3,
    RegMode = 3'd4
  } cfg_reg_e;

  // One queue entry holds both words of a pair.
  typedef struct packed {
    logic [7:0] sym0;
    logic [7:0] sym1;
    logic       last;
  } pair_t;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic [6:0] key_raw_q [4];
  logic       mode_q;
  logic       cfg_wr;
  logic [2:0] settle_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_raw_q[0] <= '0;
      key_raw_q[1] <= '0;
      key_raw_q[2] <= '0;
      key_raw_q[3] <= '0;
      mode_q       <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[4:2]))
        RegKeyA: key_raw_q[0] <= pwdata[6:0];
        RegKeyB: key_raw_q[1] <= pwdata[6:0];
        RegKeyC: key_raw_q[2] <= pwdata[6:0];
        RegKeyD: key_raw_q[3] <= pwdata[6:0];
        RegMode: mode_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[4:2]))
      RegKeyA: prdata = {25'd0, key_raw_q[0]};
      RegKeyB: prdata = {25'd0, key_raw_q[1]};
      RegKeyC: prdata = {25'd0, key_raw_q[2]};
      RegKeyD: prdata = {25'd0, key_raw_q[3]};
      RegMode: prdata = {31'd0, mode_q};
      default: prdata = '0;
    endcase
  end

  // Hold off input until the derived key has run through its pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= KeySettle;
    end else if (cfg_wr) begin
      settle_q <= KeySettle;
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  // ---------------------------------------------------------------------
  // Active key: reduce; for decrypt, det = ad - bc, inverse, adjugate times inverse.
  // Runs continuously; only changes after reset or a register write.
  // ---------------------------------------------------------------------
  logic [6:0]  red_q [4];
  logic [12:0] ad_q, bc_q;
  logic [6:0]  det_q, inv_q;
  logic [12:0] kp_q [4];
  logic [6:0]  key_q [4];
  logic [6:0]  ad_m, bc_m, det_d, neg_b, neg_c;

  always_comb begin
    ad_m  = mod67(14'(ad_q));
    bc_m  = mod67(14'(bc_q));
    det_d = (ad_m >= bc_m) ? (ad_m - bc_m)
                           : 7'(8'(ad_m) + 8'(SymCount) - 8'(bc_m));
    neg_b = (red_q[1] == '0) ? '0 : 7'(SymCount) - red_q[1];
    neg_c = (red_q[2] == '0) ? '0 : 7'(SymCount) - red_q[2];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      red_q[i] <= (key_raw_q[i] >= 7'(SymCount)) ? key_raw_q[i] - 7'(SymCount)
                                                  : key_raw_q[i];
      key_q[i] <= mode_q ? mod67(14'(kp_q[i])) : red_q[i];
    end
    ad_q    <= 13'(red_q[0]) * 13'(red_q[3]);
    bc_q    <= 13'(red_q[1]) * 13'(red_q[2]);
    det_q   <= det_d;
    inv_q   <= InvTab[det_q];
    kp_q[0] <= 13'(inv_q) * 13'(red_q[3]);
    kp_q[1] <= 13'(inv_q) * 13'(neg_b);
    kp_q[2] <= 13'(inv_q) * 13'(neg_c);
    kp_q[3] <= 13'(inv_q) * 13'(red_q[0]);
  end

  // ---------------------------------------------------------------------
  // Pairing at the input: lookup, hold first symbol, pad on last.
  // ---------------------------------------------------------------------
  logic                in_acc;
  hc67_sym_t           sym;
  logic                pending_q, pend_d;
  logic [6:0]          held_q, held_d;
  logic                emit;
  logic [6:0]          p1_d, p2_d;
  logic                plast_d;
  logic [CreditW-1:0]  credit;
  logic [CntW-1:0]     cnt_q;
  logic                s0_vld_q, s1_vld_q;

  // Every queued or in-flight pair is counted; a new byte may add one more.
  assign credit     = CreditW'(cnt_q) + CreditW'(s0_vld_q) + CreditW'(s1_vld_q);
  assign in_stall_o = (settle_q != '0) | (credit >= CreditW'(FifoDepth));
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    sym     = sym_lookup(in_word_i.in_char);
    pend_d  = pending_q;
    held_d  = held_q;
    emit    = 1'b0;
    p1_d    = held_q;
    p2_d    = sym.idx;
    plast_d = in_word_i.in_last;
    if (sym.vld) begin
      if (pending_q) begin
        emit   = 1'b1;
        pend_d = 1'b0;
        held_d = '0;
      end else begin
        pend_d = 1'b1;
        held_d = sym.idx;
      end
    end
    // odd symbol left at end of message: pad with a space
    if (in_word_i.in_last && pend_d) begin
      emit    = 1'b1;
      p1_d    = held_d;
      p2_d    = PadIndex;
      plast_d = 1'b1;
    end
    if (in_word_i.in_last) begin
      pend_d = 1'b0;
      held_d = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath: pair register -> products -> mod 67 and char map -> queue
  // ---------------------------------------------------------------------
  logic [6:0]  p1_q, p2_q;
  logic        s0_last_q, s1_last_q;
  logic [13:0] sum0_q, sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        pending_q <= pend_d;
        held_q    <= held_d;
      end
      s0_vld_q <= in_acc & emit;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc & emit) begin
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      s0_last_q <= plast_d;
    end
    sum0_q    <= 14'(p1_q) * 14'(key_q[0]) + 14'(p2_q) * 14'(key_q[2]);
    sum1_q    <= 14'(p1_q) * 14'(key_q[1]) + 14'(p2_q) * 14'(key_q[3]);
    s1_last_q <= s0_last_q;
  end

  // ---------------------------------------------------------------------
  // Output queue of pairs; half_q picks the word within the head pair.
  // ---------------------------------------------------------------------
  pair_t           mem_q [FifoDepth];
  pair_t           entry, head;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic            half_q;
  logic            push, pop, out_acc;

  assign push = s1_vld_q;
  assign entry.sym0 = sym_char(mod67(sum0_q));
  assign entry.sym1 = sym_char(mod67(sum1_q));
  assign entry.last = s1_last_q;

  assign head                = mem_q[rd_ptr_q];
  assign out_valid_o         = (cnt_q != '0);
  assign out_word_o.out_char = half_q ? head.sym1 : head.sym0;
  assign out_word_o.out_last = half_q & head.last;
  assign out_acc             = out_valid_o & ~out_stall_i;
  assign pop                 = out_acc & half_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      half_q   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
      if (out_acc) begin
        half_q <= ~half_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit <= CreditW'(FifoDepth))
    else $error("output queue overcommitted");

  a_last_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.out_last) |-> half_q)
    else $error("out_last on first word of a pair");

  a_end_clears_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.in_last) |=> !pending_q)
    else $error("symbol still held after end of message");

  a_write_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input taken while key settles");

endmodule
